[hw/rtl/cuv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cuv_pkg;

   // CORDIC vector width and angle accumulator width (2^-32 turn units)
   localparam int XW = 36;
   localparam int AW = 34;

   // pi as a half turn in 2^-32 turn units
   localparam logic signed [AW-1:0] PI_TURN = 34'sd2147483648;
   localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [AW-1:0] acc;
   } cuv_vec_type;

   // fields that ride along the square root chain
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] z;
      logic signed [15:0] y;
   } cuv_side_type;

   // bit-serial long division, elaboration use only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = 64'd0;
      r = 65'd0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-idx) in 2^-32 turn, by truncated arctan series
   function automatic logic [AW-1:0] stage_angle(input int unsigned idx);
      logic [63:0] acc;
      logic [63:0] term;
      logic [63:0] prod;
      int unsigned sh;
      acc = 64'd0;
      for (int unsigned k = 0; k < 32; k++) begin
         sh = idx * (2 * k + 1);
         if (idx != 0 && sh < 63) begin
            term = udiv64((64'd1 << 62) >> sh, 64'(2 * k + 1));
            if (k[0]) acc = acc - term;
            else acc = acc + term;
         end
      end
      prod = (acc >> 30) * INV_TWO_PI_Q32 + (64'd1 << 31);
      if (idx == 0) return AW'(536870912);
      return AW'(prod[63:32]);
   endfunction

endpackage
`default_nettype wire

[hw/rtl/cuv_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module cuv_sqrt_cell #(
   parameter int RW   = 29,
   parameter int BPOS = 28
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [RW-1:0]         n_i,
   input  logic [RW-1:0]         r_i,
   input  cuv_pkg::cuv_side_type side_i,
   output logic [RW-1:0]         n_o,
   output logic [RW-1:0]         r_o,
   output cuv_pkg::cuv_side_type side_o
);
   import cuv_pkg::*;

   localparam logic [RW-1:0] BIT = RW'(1) << BPOS;

   logic [RW:0]   trial;
   logic [RW-1:0] n_ff, n_in, r_ff, r_in;
   cuv_side_type  side_ff;

   always_comb begin
      trial = {1'b0, r_i} + {1'b0, BIT};
      if ({1'b0, n_i} >= trial) begin
         n_in = n_i - trial[RW-1:0];
         r_in = (r_i >> 1) + BIT;
      end else begin
         n_in = n_i;
         r_in = r_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff    <= n_in;
         r_ff    <= r_in;
         side_ff <= side_i;
      end
   end

   assign n_o    = n_ff;
   assign r_o    = r_ff;
   assign side_o = side_ff;

endmodule
`default_nettype wire

[hw/rtl/cuv_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module cuv_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 en,
   input  cuv_pkg::cuv_vec_type vec_i,
   output cuv_pkg::cuv_vec_type vec_o
);
   import cuv_pkg::*;

   localparam logic signed [AW-1:0] ANGLE = signed'(stage_angle(STAGE));

   logic signed [XW-1:0] dx, dy;
   cuv_vec_type vec_ff, vec_in;

   always_comb begin
      dx = vec_i.y >>> STAGE;
      dy = vec_i.x >>> STAGE;
      // rotate toward the positive x axis
      if (!vec_i.y[XW-1]) begin
         vec_in.x   = vec_i.x + dx;
         vec_in.y   = vec_i.y - dy;
         vec_in.acc = vec_i.acc + ANGLE;
      end else begin
         vec_in.x   = vec_i.x - dx;
         vec_in.y   = vec_i.y + dy;
         vec_in.acc = vec_i.acc - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) vec_ff <= vec_in;
   end

   assign vec_o = vec_ff;

endmodule
`default_nettype wire

[hw/rtl/normal_to_cylinder_uv_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Cylindrical UV mapping of a unit normal.
// req_ channel: one word per normal, x, y, z in signed Q1.14.
// rsp_ channel: one word per normal, u = atan2(x, z) / 2pi in 1/65536 turn
// and v = acos(y) / pi in 1/65536, 0 at y = +1.
// Datapath: input register, y*y register, FRAC_BITS+1 square root cells
// (one root bit each), a pre-rotation register, then two rows of
// CORDIC_STAGES cells (u and v side by side, one shift-add step each).
// Throughput: one word per cycle while the skid register is empty; every
// cell does one step per cycle on which the enable is high.
// The whole chain moves on one enable. An output register plus a skid
// register sit at the end, so a word keeps being taken while a result waits;
// when both hold a word, req_tready drops until rsp_tready takes one.
// Reset clears the valid line and the valid bits of both output registers;
// data in flight is dropped. No clearing pass is needed.
module normal_to_cylinder_uv_core #(
   parameter int FRAC_BITS     = 14,
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // normal_x, normal_y, normal_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // u_turn, v_half_turn, zero pad
);
   import cuv_pkg::*;

   localparam int NS  = FRAC_BITS + 1;
   localparam int RW  = 2 * FRAC_BITS + 1;
   localparam int SHV = 32 - FRAC_BITS;
   localparam int CS  = CORDIC_STAGES;
   localparam int L   = NS + CS + 3;
   localparam logic signed [31:0] ONE_S = 32'sd1 <<< FRAC_BITS;
   localparam logic [RW-1:0] ONE2 = RW'(1) << (2 * FRAC_BITS);

   function automatic cuv_vec_type pre_rot(input logic signed [XW-1:0] x,
                                           input logic signed [XW-1:0] y);
      cuv_vec_type v;
      v.x   = x;
      v.y   = y;
      v.acc = '0;
      if (x[XW-1]) begin
         v.acc = y[XW-1] ? -PI_TURN : PI_TURN;
         v.x   = -x;
         v.y   = -y;
      end
      return v;
   endfunction

   logic run;
   logic [L-1:0] vld_ff;

   // input stage
   logic signed [31:0] y_wide;
   cuv_side_type in_side, s0_ff;
   // radicand stage
   logic [31:0]   ysq;
   logic [RW-1:0] rad_ff;
   cuv_side_type  s1_ff;

   logic [RW-1:0] sq_n [0:NS];
   logic [RW-1:0] sq_r [0:NS];
   cuv_side_type  sq_side [0:NS];

   // pre-rotation stage
   logic [NS-1:0]        root;
   logic signed [XW-1:0] vx, vy;
   cuv_vec_type          upre_in, vpre_in;
   cuv_vec_type          upre_ff, vpre_ff;
   logic [CS:0]          zline_ff;

   cuv_vec_type u_vec [0:CS];
   cuv_vec_type v_vec [0:CS];

   // rounding
   logic signed [AW:0]    ur_sum, vr_sum;
   logic signed [AW-16:0] u_sh;
   logic signed [AW-15:0] v_sh;
   logic [16:0]           u_res, v_res;

   logic        push, pop;
   logic        out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic [33:0] out_data_ff, out_data_in, skid_data_ff, skid_data_in;

   assign run        = !skid_valid_ff;
   assign req_tready = run;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (run) vld_ff <= {vld_ff[L-2:0], req_tvalid};
   end

   always_comb begin
      in_side.x = signed'(req_tdata[15:0]);
      in_side.z = signed'(req_tdata[47:32]);
      y_wide    = 32'(signed'(req_tdata[31:16]));
      if (y_wide > ONE_S) in_side.y = ONE_S[15:0];
      else if (y_wide < -ONE_S) in_side.y = -ONE_S[15:0];
      else in_side.y = y_wide[15:0];
   end

   // square taken at full 32-bit width
   assign ysq = unsigned'(32'(s0_ff.y) * 32'(s0_ff.y));

   always_ff @(posedge clock) begin
      if (run) begin
         s0_ff  <= in_side;
         s1_ff  <= s0_ff;
         rad_ff <= ONE2 - RW'(ysq);
      end
   end

   assign sq_n[0]    = rad_ff;
   assign sq_r[0]    = '0;
   assign sq_side[0] = s1_ff;

   for (genvar j = 0; j < NS; j++) begin : g_sqrt
      cuv_sqrt_cell #(
         .RW   (RW),
         .BPOS (2 * (NS - 1 - j))
      ) u_cell (
         .clock  (clock),
         .en     (run),
         .n_i    (sq_n[j]),
         .r_i    (sq_r[j]),
         .side_i (sq_side[j]),
         .n_o    (sq_n[j+1]),
         .r_o    (sq_r[j+1]),
         .side_o (sq_side[j+1])
      );
   end

   always_comb begin
      root    = sq_r[NS][NS-1:0];
      vx      = XW'(sq_side[NS].y) <<< SHV;
      vy      = signed'(XW'(root)) <<< SHV;
      upre_in = pre_rot({{(XW-32){sq_side[NS].z[15]}}, sq_side[NS].z, 16'd0},
                        {{(XW-32){sq_side[NS].x[15]}}, sq_side[NS].x, 16'd0});
      vpre_in = pre_rot(vx, vy);
   end

   always_ff @(posedge clock) begin
      if (run) begin
         upre_ff  <= upre_in;
         vpre_ff  <= vpre_in;
         zline_ff <= {zline_ff[CS-1:0], (sq_side[NS].x == 16'sd0) && (sq_side[NS].z == 16'sd0)};
      end
   end

   assign u_vec[0] = upre_ff;
   assign v_vec[0] = vpre_ff;

   for (genvar i = 0; i < CS; i++) begin : g_cordic
      cuv_cordic_cell #(.STAGE(i)) u_cell_u (
         .clock (clock),
         .en    (run),
         .vec_i (u_vec[i]),
         .vec_o (u_vec[i+1])
      );
      cuv_cordic_cell #(.STAGE(i)) u_cell_v (
         .clock (clock),
         .en    (run),
         .vec_i (v_vec[i]),
         .vec_o (v_vec[i+1])
      );
   end

   always_comb begin
      ur_sum = {u_vec[CS].acc[AW-1], u_vec[CS].acc} + 35'sd32768;
      vr_sum = {v_vec[CS].acc[AW-1], v_vec[CS].acc} + 35'sd16384;
      u_sh   = ur_sum[AW:16];
      v_sh   = vr_sum[AW:15];
      if (zline_ff[CS]) u_res = 17'd0;
      else if (u_sh > 32'sd32768) u_res = 17'h08000;
      else if (u_sh < -32'sd32768) u_res = 17'h18000;
      else u_res = u_sh[16:0];
      if (v_sh < 32'sd0) v_res = 17'd0;
      else if (v_sh > 32'sd65536) v_res = 17'h10000;
      else v_res = v_sh[16:0];
   end

   // output register with skid
   assign push = run && vld_ff[L-1];
   assign pop  = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = {v_res, u_res};
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = {v_res, u_res};
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_data_ff};

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with output register empty");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (run && vld_ff[L-1]) |-> !(out_valid_ff && skid_valid_ff))
      else $error("result pushed into full output buffer");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted word missing from valid line");

   a_v_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33:17] <= 17'd65536))
      else $error("v result out of range");

endmodule
`default_nettype wire
